// File: hdl/pixel_format_pack_ordered_dither_top_defines.svh
// Assertion macros shared by the verification files of the pixel packer.
`ifndef PIXEL_FORMAT_PACK_ORDERED_DITHER_TOP_DEFINES_SVH
`define PIXEL_FORMAT_PACK_ORDERED_DITHER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define PFPOD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define PFPOD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/pfpod_pkg.sv
// Shared types, register map, dither matrix and channel helpers of the pixel packer.
package pfpod_pkg;

    localparam int unsigned MAX_WIDTH_DEFAULT = 4096;
    localparam int unsigned IMAGE_WIDTH_W     = 13;
    localparam int unsigned PADDR_W           = 4;
    localparam int unsigned PDATA_W           = 32;

    typedef enum logic [1:0] {
        FMT_RGBA8888 = 2'd0,
        FMT_RGBA4444 = 2'd1,
        FMT_RGB565   = 2'd2
    } format_t;

    localparam logic [PADDR_W-1:0] ADDR_OUTPUT_FORMAT = 4'h0;
    localparam logic [PADDR_W-1:0] ADDR_DITHER_ENABLE = 4'h4;
    localparam logic [PADDR_W-1:0] ADDR_IMAGE_WIDTH   = 4'h8;

    localparam logic [1:0]               FORMAT_RESET = FMT_RGBA4444;
    localparam logic                     DITHER_RESET = 1'b1;
    localparam logic [IMAGE_WIDTH_W-1:0] WIDTH_RESET  = 13'd4096;

    // 4x4 ordered dither matrix, row-major, entries 1..16.
    localparam logic [4:0] DITHER_MATRIX [16] = '{
        5'd1,  5'd9,  5'd3,  5'd11,
        5'd13, 5'd5,  5'd15, 5'd7,
        5'd4,  5'd12, 5'd2,  5'd10,
        5'd16, 5'd8,  5'd14, 5'd6
    };

    localparam logic [4:0] DITHER_BIAS = 5'd8;

    typedef logic signed [4:0] offset_t;

    // Adds the dither offset, drops four bits and clamps to 0..15.
    function automatic logic [3:0] to_nibble(input logic [7:0] chan, input offset_t offset);
        logic signed [9:0] sum;
        begin
            sum = $signed({2'b00, chan}) + $signed({{5{offset[4]}}, offset});
            if (sum[9])
                to_nibble = 4'd0;
            else if (sum[8])
                to_nibble = 4'd15;
            else
                to_nibble = sum[7:4];
        end
    endfunction

endpackage

// File: hdl/pixel_format_pack_ordered_dither_top.sv
// Top level of the pixel packer: APB registers, position counters and a two-stage pixel path.
//
// Packs one RGBA8888 pixel per clock into RGBA8888, RGBA4444 with optional 4x4
// ordered dither, or RGB565; the reserved format code gives an all-zero word. A
// pixel is accepted every cycle the downstream side keeps up. Each result passes
// through the input stage, which also holds the dither offset picked from the
// column and row counters, and then the output register, which holds the word
// after the channels are offset, clamped and packed. While a finished word
// waits in the output register, the input stage takes at most one more pixel
// and then holds pixel_ready low until the word is taken. Registers are written
// through APB and should only be changed while no pixel is in flight.
// frame_start on a pixel restarts the dither pattern at column 0, row 0.
module pixel_format_pack_ordered_dither_top #(
    parameter int unsigned MAX_WIDTH = pfpod_pkg::MAX_WIDTH_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pfpod_pkg::PADDR_W-1:0]  paddr,
    input  logic [pfpod_pkg::PDATA_W-1:0]  pwdata,
    output logic [pfpod_pkg::PDATA_W-1:0]  prdata,
    output logic                           pready,
    input  logic                           pixel_valid,
    output logic                           pixel_ready,
    input  logic [7:0]                     red,
    input  logic [7:0]                     green,
    input  logic [7:0]                     blue,
    input  logic [7:0]                     alpha,
    input  logic                           frame_start,
    output logic                           word_valid,
    input  logic                           word_ready,
    output logic [31:0]                    pixel_word
);

    localparam int unsigned CW  = $clog2(MAX_WIDTH);
    localparam int unsigned EWN = $clog2(MAX_WIDTH + 1);
    localparam int unsigned EW  = (EWN > pfpod_pkg::IMAGE_WIDTH_W) ? EWN
                                                                   : pfpod_pkg::IMAGE_WIDTH_W;

    // Configuration registers
    logic [1:0]                          output_format_reg;
    logic                                dither_enable_reg;
    logic [pfpod_pkg::IMAGE_WIDTH_W-1:0] image_width_reg;

    // Position counters
    logic [CW-1:0] column_count_reg, column_count_next;
    logic [1:0]    row_phase_reg, row_phase_next;

    // Input stage
    logic               s1_valid_reg;
    logic [7:0]         s1_red_reg, s1_green_reg, s1_blue_reg, s1_alpha_reg;
    pfpod_pkg::offset_t s1_offset_reg;

    // Output stage
    logic        out_valid_reg;
    logic [31:0] out_word_reg, out_word_next;

    logic               cfg_write;
    logic               pixel_take;
    logic               s1_advance;
    logic [CW-1:0]      column_cur;
    logic [1:0]         row_cur;
    logic [4:0]         matrix_entry;
    pfpod_pkg::offset_t offset_cur;
    logic [EW-1:0]      width_ext;
    logic [EW-1:0]      width_eff;
    logic [EW-1:0]      column_inc;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            output_format_reg <= pfpod_pkg::FORMAT_RESET;
            dither_enable_reg <= pfpod_pkg::DITHER_RESET;
            image_width_reg   <= pfpod_pkg::WIDTH_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr)
                pfpod_pkg::ADDR_OUTPUT_FORMAT: output_format_reg <= pwdata[1:0];
                pfpod_pkg::ADDR_DITHER_ENABLE: dither_enable_reg <= pwdata[0];
                pfpod_pkg::ADDR_IMAGE_WIDTH:
                    image_width_reg <= pwdata[pfpod_pkg::IMAGE_WIDTH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr)
            pfpod_pkg::ADDR_OUTPUT_FORMAT:
                prdata = {{(pfpod_pkg::PDATA_W-2){1'b0}}, output_format_reg};
            pfpod_pkg::ADDR_DITHER_ENABLE:
                prdata = {{(pfpod_pkg::PDATA_W-1){1'b0}}, dither_enable_reg};
            pfpod_pkg::ADDR_IMAGE_WIDTH:
                prdata = {{(pfpod_pkg::PDATA_W-pfpod_pkg::IMAGE_WIDTH_W){1'b0}},
                          image_width_reg};
            default:
                prdata = '0;
        endcase
    end

    // Handshake: the input stage drains whenever the output register is empty or being taken.
    assign s1_advance  = s1_valid_reg && (!out_valid_reg || word_ready);
    assign pixel_ready = !s1_valid_reg || s1_advance;
    assign pixel_take  = pixel_valid && pixel_ready;

    // Position of the current pixel and its dither offset.
    assign column_cur   = frame_start ? '0 : column_count_reg;
    assign row_cur      = frame_start ? 2'd0 : row_phase_reg;
    assign matrix_entry = pfpod_pkg::DITHER_MATRIX[{row_cur, column_cur[1:0]}];
    assign offset_cur   = dither_enable_reg ? $signed(matrix_entry - pfpod_pkg::DITHER_BIAS)
                                            : 5'sd0;

    // A width of zero or beyond the maximum counts as the maximum.
    assign width_ext  = EW'(image_width_reg);
    assign width_eff  = ((image_width_reg == '0) || (width_ext > EW'(MAX_WIDTH)))
                        ? EW'(MAX_WIDTH) : width_ext;
    assign column_inc = EW'(column_cur) + EW'(1);

    always_comb
    begin
        if (column_inc >= width_eff)
        begin
            column_count_next = '0;
            row_phase_next    = row_cur + 2'd1;
        end
        else
        begin
            column_count_next = column_inc[CW-1:0];
            row_phase_next    = row_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= '0;
            row_phase_reg    <= '0;
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (pixel_take)
            begin
                column_count_reg <= column_count_next;
                row_phase_reg    <= row_phase_next;
            end
            if (pixel_ready)
                s1_valid_reg <= pixel_valid;
            if (!out_valid_reg || word_ready)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pixel_take)
        begin
            s1_red_reg    <= red;
            s1_green_reg  <= green;
            s1_blue_reg   <= blue;
            s1_alpha_reg  <= alpha;
            s1_offset_reg <= offset_cur;
        end
        if (s1_advance)
            out_word_reg <= out_word_next;
    end

    always_comb
    begin
        case (output_format_reg)
            pfpod_pkg::FMT_RGBA8888:
                out_word_next = {s1_alpha_reg, s1_blue_reg, s1_green_reg, s1_red_reg};
            pfpod_pkg::FMT_RGBA4444:
                out_word_next = {16'h0000,
                                 pfpod_pkg::to_nibble(s1_red_reg,   s1_offset_reg),
                                 pfpod_pkg::to_nibble(s1_green_reg, s1_offset_reg),
                                 pfpod_pkg::to_nibble(s1_blue_reg,  s1_offset_reg),
                                 pfpod_pkg::to_nibble(s1_alpha_reg, s1_offset_reg)};
            pfpod_pkg::FMT_RGB565:
                out_word_next = {16'h0000, s1_red_reg[7:3], s1_green_reg[7:2],
                                 s1_blue_reg[7:3]};
            default:
                out_word_next = '0;
        endcase
    end

    assign word_valid = out_valid_reg;
    assign pixel_word = out_word_reg;

endmodule

// File: hdl/pfpod_checker.sv
// Port-level checker for the pixel packer and its bind to the top level.
`include "pixel_format_pack_ordered_dither_top_defines.svh"

module pfpod_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           psel,
    input logic                           penable,
    input logic                           pwrite,
    input logic [pfpod_pkg::PADDR_W-1:0]  paddr,
    input logic [pfpod_pkg::PDATA_W-1:0]  prdata,
    input logic                           pready,
    input logic                           pixel_valid,
    input logic                           pixel_ready,
    input logic                           word_valid,
    input logic                           word_ready,
    input logic [31:0]                    pixel_word
);

    // The register port never inserts wait states.
    `PFPOD_ASSERT_NOW(a_pready_high, 1'b1, pready, "pready dropped")

    // With the output register empty nothing can hold back a new pixel.
    `PFPOD_ASSERT_NOW(a_ready_when_empty, !word_valid, pixel_ready,
                      "pixel_ready low while no word is pending")

    // A word that is not taken stays in place.
    `PFPOD_ASSERT_NEXT(a_word_holds, word_valid && !word_ready,
                       word_valid && $stable(pixel_word), "pending word changed or vanished")

    // Reading the dither enable shows only its single bit.
    `PFPOD_ASSERT_NOW(a_dither_readback,
                      psel && !pwrite && (paddr == pfpod_pkg::ADDR_DITHER_ENABLE),
                      prdata[pfpod_pkg::PDATA_W-1:1] == '0,
                      "dither enable readback has stray bits")

endmodule

bind pixel_format_pack_ordered_dither_top pfpod_checker u_pfpod_checker (.*);

// File: sim/pixel_format_pack_ordered_dither_top_test.sv
// Self-checking testbench for the ordered-dither pixel packer: directed table, then random phases.
`timescale 1ns / 100ps

module pixel_format_pack_ordered_dither_top_test;

    localparam logic [1:0]  FMT_RESERVED     = 2'd3;
    localparam int unsigned FULL_WIDTH       = pfpod_pkg::MAX_WIDTH_DEFAULT;
    localparam int          DIRECTED_ROWS    = 25;
    localparam int          RANDOM_PHASES    = 12;
    localparam int          PIXELS_PER_PHASE = 120;
    localparam int          SETTLE_CYCLES    = 4;

    // Bayer levels in raster order of the 4x4 tile; index is row*4 + column.
    localparam logic [0:15][4:0] BAYER = {
        5'd1,  5'd9,  5'd3,  5'd11,
        5'd13, 5'd5,  5'd15, 5'd7,
        5'd4,  5'd12, 5'd2,  5'd10,
        5'd16, 5'd8,  5'd14, 5'd6
    };

    typedef struct packed {
        logic [1:0]  fmt;
        logic        dith;
        logic [12:0] width;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic [7:0]  a;
        logic        fs;
        logic        literal;
        logic [31:0] word;
    } directed_row_t;

    logic                           clk         = 1'b0;
    logic                           rst_n       = 1'b0;
    logic                           psel        = 1'b0;
    logic                           penable     = 1'b0;
    logic                           pwrite      = 1'b0;
    logic [pfpod_pkg::PADDR_W-1:0]  paddr       = '0;
    logic [pfpod_pkg::PDATA_W-1:0]  pwdata      = '0;
    logic [pfpod_pkg::PDATA_W-1:0]  prdata;
    logic                           pready;
    logic                           pixel_valid = 1'b0;
    logic                           pixel_ready;
    logic [7:0]                     red         = '0;
    logic [7:0]                     green       = '0;
    logic [7:0]                     blue        = '0;
    logic [7:0]                     alpha       = '0;
    logic                           frame_start = 1'b0;
    logic                           word_valid;
    logic                           word_ready  = 1'b0;
    logic [31:0]                    pixel_word;

    // Predictor state: register copies and the dither position.
    logic [1:0]           cfg_format = pfpod_pkg::FMT_RGBA4444;
    logic                 cfg_dither = 1'b1;
    logic [12:0]          cfg_width  = 13'd4096;
    int                   col_pos    = 0;
    int                   row_pos    = 0;

    logic [31:0]          pending_words [$];
    directed_row_t        rows [DIRECTED_ROWS];
    bit                   idle_on       = 1'b1;
    int                   mismatches    = 0;
    int                   words_checked = 0;
    int                   pixels_sent   = 0;
    int                   settings_used = 1;

    pixel_format_pack_ordered_dither_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .alpha       (alpha),
        .frame_start (frame_start),
        .word_valid  (word_valid),
        .word_ready  (word_ready),
        .pixel_word  (pixel_word)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("MISMATCH at %0t ns: %s: got %h, expected %h", $time, what, got, want);
    endtask

    // Packs one pixel the way the block should and advances the dither position.
    function automatic logic [31:0] predict_word(input logic [7:0] r, input logic [7:0] g,
                                                 input logic [7:0] b, input logic [7:0] a,
                                                 input logic fs);
        int          offset;
        int          level;
        int          span;
        logic [7:0]  chans [4];
        logic [31:0] word;
        chans[0] = r;
        chans[1] = g;
        chans[2] = b;
        chans[3] = a;
        if (fs)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        offset = cfg_dither ? int'(BAYER[row_pos * 4 + col_pos % 4]) - 8 : 0;
        word = '0;
        case (cfg_format)
            pfpod_pkg::FMT_RGBA8888: word = {a, b, g, r};
            pfpod_pkg::FMT_RGBA4444:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    level = int'(chans[i]) + offset;
                    if (level < 0)
                        level = 0;
                    level = level / 16;
                    if (level > 15)
                        level = 15;
                    word = {word[27:0], level[3:0]};
                end
            end
            pfpod_pkg::FMT_RGB565:   word = {16'h0000, r[7:3], g[7:2], b[7:3]};
            default:                 word = '0;
        endcase
        // Zero or oversized widths fall back to the full line length.
        span = (cfg_width == 0 || cfg_width > FULL_WIDTH) ? FULL_WIDTH : int'(cfg_width);
        col_pos++;
        if (col_pos >= span)
        begin
            col_pos = 0;
            row_pos = (row_pos + 1) % 4;
        end
        return word;
    endfunction

    function automatic logic [7:0] random_channel();
        int pick;
        pick = $urandom_range(0, 5);
        if (pick == 0)
            return 8'($urandom_range(0, 8));
        else if (pick == 1)
            return 8'($urandom_range(247, 255));
        return 8'($urandom);
    endfunction

    // Called at a rising edge; returns at the edge where the item was accepted.
    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                              input logic [7:0] a, input logic fs, input logic literal,
                              input logic [31:0] literal_word);
        logic [31:0] predicted;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            pixel_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        pixel_valid <= 1'b1;
        red         <= r;
        green       <= g;
        blue        <= b;
        alpha       <= a;
        frame_start <= fs;
        do @(posedge clk); while (!pixel_ready);
        predicted = predict_word(r, g, b, a, fs);
        pending_words.push_back(literal ? literal_word : predicted);
        pixels_sent++;
    endtask

    task automatic wait_for_words();
        pixel_valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes a register, then reads it back in the following transfer.
    task automatic write_and_verify(input logic [pfpod_pkg::PADDR_W-1:0] addr,
                                    input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== data)
            report_mismatch($sformatf("readback of register at %h", addr), prdata, data);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_settings(input logic [1:0] fmt, input logic dith,
                                  input logic [12:0] width, input bit all_regs);
        if (all_regs || fmt != cfg_format || dith != cfg_dither || width != cfg_width)
        begin
            wait_for_words();
            if (all_regs || fmt != cfg_format)
                write_and_verify(pfpod_pkg::ADDR_OUTPUT_FORMAT, {30'd0, fmt});
            if (all_regs || dith != cfg_dither)
                write_and_verify(pfpod_pkg::ADDR_DITHER_ENABLE, {31'd0, dith});
            if (all_regs || width != cfg_width)
                write_and_verify(pfpod_pkg::ADDR_IMAGE_WIDTH, {19'd0, width});
            cfg_format = fmt;
            cfg_dither = dith;
            cfg_width  = width;
            settings_used++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && word_valid && word_ready)
        begin
            if (pending_words.size() == 0)
                report_mismatch("word with no pixel pending", pixel_word, 32'h0);
            else if (pixel_word !== pending_words[0])
                report_mismatch("pixel_word", pixel_word, pending_words.pop_front());
            else
                void'(pending_words.pop_front());
            words_checked++;
        end
    end

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (idle_on && $urandom_range(0, 5) == 0)
            begin
                word_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            word_ready <= 1'b1;
        end
    end

    initial
    begin
        #2_000_000;
        $display("Timed out with %0d words outstanding", pending_words.size());
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        logic [1:0]  fmt;
        logic        dith;
        logic [12:0] wid;
        int          pick;

        // Reset values first, then each format, dither off, and width extremes.
        rows[0]  = '{pfpod_pkg::FMT_RGBA4444, 1'b1, 13'd4096, 8'h00, 8'h00, 8'h00, 8'h00,
                     1'b1, 1'b1, 32'h0};
        rows[1]  = '{pfpod_pkg::FMT_RGBA4444, 1'b1, 13'd4096, 8'hff, 8'hff, 8'hff, 8'hff,
                     1'b0, 1'b1, 32'h0000ffff};
        rows[2]  = '{pfpod_pkg::FMT_RGBA4444, 1'b1, 13'd4096, 8'h80, 8'h7f, 8'h08, 8'hf7,
                     1'b0, 1'b0, 32'h0};
        rows[3]  = '{pfpod_pkg::FMT_RGBA4444, 1'b1, 13'd4096, 8'h07, 8'h08, 8'hf8, 8'hf0,
                     1'b0, 1'b0, 32'h0};
        rows[4]  = '{pfpod_pkg::FMT_RGBA8888, 1'b1, 13'd4, 8'h11, 8'h22, 8'h33, 8'h44,
                     1'b1, 1'b1, 32'h44332211};
        rows[5]  = '{pfpod_pkg::FMT_RGBA8888, 1'b1, 13'd4, 8'hff, 8'h00, 8'hff, 8'h00,
                     1'b0, 1'b1, 32'h00ff00ff};
        rows[6]  = '{pfpod_pkg::FMT_RGBA8888, 1'b1, 13'd4, 8'h5a, 8'ha5, 8'hc3, 8'h3c,
                     1'b0, 1'b1, 32'h3cc3a55a};
        rows[7]  = '{pfpod_pkg::FMT_RGB565, 1'b1, 13'd4, 8'hff, 8'hff, 8'hff, 8'hff,
                     1'b0, 1'b1, 32'h0000ffff};
        rows[8]  = '{pfpod_pkg::FMT_RGB565, 1'b1, 13'd4, 8'h08, 8'h04, 8'h08, 8'h00,
                     1'b0, 1'b1, 32'h00000821};
        rows[9]  = '{pfpod_pkg::FMT_RGB565, 1'b1, 13'd4, 8'h07, 8'h03, 8'h07, 8'hff,
                     1'b0, 1'b1, 32'h0};
        rows[10] = '{FMT_RESERVED, 1'b0, 13'd1, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1, 1'b1, 32'h0};
        rows[11] = '{FMT_RESERVED, 1'b0, 13'd1, 8'h12, 8'h34, 8'h56, 8'h78, 1'b0, 1'b1, 32'h0};
        rows[12] = '{pfpod_pkg::FMT_RGBA4444, 1'b0, 13'd1, 8'hff, 8'h7f, 8'h10, 8'h0f,
                     1'b0, 1'b1, 32'h0000f710};
        rows[13] = '{pfpod_pkg::FMT_RGBA4444, 1'b0, 13'd1, 8'h00, 8'h80, 8'hef, 8'hf0,
                     1'b0, 1'b1, 32'h000008ef};
        rows[14] = '{pfpod_pkg::FMT_RGBA4444, 1'b1, 13'd3, 8'h08, 8'hf7, 8'h00, 8'hff,
                     1'b1, 1'b0, 32'h0};
        rows[15] = '{pfpod_pkg::FMT_RGBA4444, 1'b1, 13'd3, 8'h09, 8'hf8, 8'h10, 8'hef,
                     1'b0, 1'b0, 32'h0};
        rows[16] = '{pfpod_pkg::FMT_RGBA4444, 1'b1, 13'd3, 8'hf9, 8'h06, 8'hf0, 8'h0f,
                     1'b0, 1'b0, 32'h0};
        rows[17] = '{pfpod_pkg::FMT_RGBA4444, 1'b1, 13'd3, 8'h7f, 8'h80, 8'h81, 8'h7e,
                     1'b0, 1'b0, 32'h0};
        rows[18] = '{pfpod_pkg::FMT_RGBA4444, 1'b1, 13'd3, 8'h00, 8'hff, 8'h08, 8'hf8,
                     1'b0, 1'b0, 32'h0};
        rows[19] = '{pfpod_pkg::FMT_RGBA4444, 1'b1, 13'd3, 8'hfe, 8'h01, 8'hf1, 8'h0e,
                     1'b0, 1'b0, 32'h0};
        rows[20] = '{pfpod_pkg::FMT_RGBA4444, 1'b1, 13'd0, 8'hff, 8'h00, 8'h7f, 8'h80,
                     1'b1, 1'b0, 32'h0};
        rows[21] = '{pfpod_pkg::FMT_RGBA4444, 1'b1, 13'd8191, 8'h01, 8'hfe, 8'h02, 8'hfd,
                     1'b0, 1'b0, 32'h0};
        rows[22] = '{pfpod_pkg::FMT_RGBA4444, 1'b1, 13'd4096, 8'h10, 8'h20, 8'h30, 8'h40,
                     1'b1, 1'b0, 32'h0};
        rows[23] = '{pfpod_pkg::FMT_RGBA4444, 1'b1, 13'd2, 8'h04, 8'hf4, 8'h0c, 8'hf8,
                     1'b1, 1'b0, 32'h0};
        rows[24] = '{pfpod_pkg::FMT_RGBA4444, 1'b1, 13'd2, 8'hf4, 8'h04, 8'hf8, 8'h0c,
                     1'b0, 1'b0, 32'h0};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            apply_settings(rows[i].fmt, rows[i].dith, rows[i].width, 1'b0);
            send_pixel(rows[i].r, rows[i].g, rows[i].b, rows[i].a, rows[i].fs,
                       rows[i].literal, rows[i].word);
        end

        // Each phase writes fresh settings and opens with a frame start; the first four hit the extremes.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase < 4)
                fmt = 2'(phase);
            else
            begin
                pick = $urandom_range(0, 9);
                fmt = (pick < 2) ? pfpod_pkg::FMT_RGBA8888 :
                      (pick < 7) ? pfpod_pkg::FMT_RGBA4444 :
                      (pick < 9) ? pfpod_pkg::FMT_RGB565 : FMT_RESERVED;
            end
            dith = ($urandom_range(0, 3) != 0);
            case (phase)
                0:       wid = 13'd1;
                1:       wid = 13'd8191;
                2:       wid = 13'd0;
                3:       wid = 13'd4096;
                default:
                begin
                    pick = $urandom_range(0, 9);
                    if (pick < 7)
                        wid = 13'($urandom_range(1, 9));
                    else if (pick < 9)
                        wid = 13'($urandom_range(10, 300));
                    else
                        wid = 13'($urandom_range(4097, 8191));
                end
            endcase
            apply_settings(fmt, dith, wid, 1'b1);
            if (phase == RANDOM_PHASES - 1)
                idle_on = 1'b0;
            for (int n = 0; n < PIXELS_PER_PHASE; n++)
                send_pixel(random_channel(), random_channel(), random_channel(),
                           random_channel(), n == 0 || $urandom_range(0, 49) == 0,
                           1'b0, 32'h0);
        end

        wait_for_words();
        repeat (10) @(posedge clk);
        $display("Sent %0d pixels under %0d register settings and checked %0d packed words.",
                 pixels_sent, settings_used, words_checked);
        $display("All formats, dither on and off, widths 0 to 8191 and frame restarts were run.");
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: sim.f
+incdir+hdl
hdl/pfpod_pkg.sv
hdl/pixel_format_pack_ordered_dither_top.sv
hdl/pfpod_checker.sv
sim/pixel_format_pack_ordered_dither_top_test.sv
